FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL files; swt_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define SWT_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a consequent holds whenever an antecedent holds.
`define SWT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/swt_pkg.sv
package swt_pkg;

    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;

    // Result slots per input beat: step result, line-close result, line marker
    localparam int SLOTS = 3;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        logic       token_end;
        logic       line_end;
    } swt_result_t;

    typedef struct packed {
        logic [SLOTS-1:0]        valid;
        swt_result_t [SLOTS-1:0] res;
    } swt_bundle_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic is_special(input logic [7:0] b);
        return (b == CH_DQUOTE) || (b == CH_SQUOTE) || (b == CH_HASH);
    endfunction

endpackage

FILE: hdl/swt_front.sv
module swt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_in,
    input  logic                line_last,
    input  logic                q_full,
    output logic                push,
    output swt_pkg::swt_bundle_t push_data
);

    typedef enum logic [1:0] {
        BETWEEN,
        IN_WORD,
        IN_QUOTED,
        IN_COMMENT
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic       hv_reg, hv_next;
    logic       pb_reg, pb_next;
    logic       thc_reg, thc_next;
    logic [7:0] qc_reg, qc_next;

    logic                 accept;
    swt_pkg::swt_bundle_t bundle;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Classify the beat, build its results and the next scan state
    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        hv_next   = hv_reg;
        pb_next   = (byte_in == swt_pkg::CH_BACKSLASH);
        thc_next  = thc_reg;
        qc_next   = qc_reg;
        bundle    = '0;

        case (mode_reg)
            BETWEEN:
            begin
                if (swt_pkg::is_ws(byte_in))
                begin
                    mode_next = BETWEEN;
                end
                else if (byte_in == swt_pkg::CH_HASH)
                begin
                    mode_next = IN_COMMENT;
                end
                else if ((byte_in == swt_pkg::CH_DQUOTE) || (byte_in == swt_pkg::CH_SQUOTE))
                begin
                    mode_next = IN_QUOTED;
                    qc_next   = byte_in;
                    held_next = '0;
                    hv_next   = 1'b0;
                    thc_next  = 1'b0;
                end
                else
                begin
                    // start a word: hold is empty, so nothing leaves yet
                    mode_next = IN_WORD;
                    held_next = byte_in;
                    hv_next   = 1'b1;
                    thc_next  = 1'b1;
                end
            end
            IN_WORD, IN_QUOTED:
            begin
                if ((mode_reg == IN_WORD) ? swt_pkg::is_ws(byte_in)
                                          : ((byte_in == qc_reg) && !pb_reg))
                begin
                    // close the token with the held byte or as empty
                    bundle.valid[0] = 1'b1;
                    bundle.res[0]   = hv_reg ? {held_reg, 3'b110} : {8'h00, 3'b010};
                    mode_next       = BETWEEN;
                    held_next       = '0;
                    hv_next         = 1'b0;
                    thc_next        = 1'b0;
                end
                else
                begin
                    // take the byte; drop a backslash before a special char
                    if (hv_reg && !((held_reg == swt_pkg::CH_BACKSLASH) &&
                                    swt_pkg::is_special(byte_in)))
                    begin
                        bundle.valid[0] = 1'b1;
                        bundle.res[0]   = {held_reg, 3'b100};
                    end
                    held_next = byte_in;
                    hv_next   = 1'b1;
                    thc_next  = 1'b1;
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        // Close an open token at line end, then add the line marker
        if (line_last)
        begin
            if (mode_next == IN_WORD)
            begin
                bundle.valid[1] = 1'b1;
                bundle.res[1]   = hv_next ? {held_next, 3'b110} : {8'h00, 3'b010};
            end
            else if (mode_next == IN_QUOTED)
            begin
                bundle.valid[1] = 1'b1;
                bundle.res[1]   = (thc_next && hv_next) ? {held_next, 3'b110}
                                                        : {qc_next, 3'b110};
            end
            bundle.valid[2] = 1'b1;
            bundle.res[2]   = {8'h00, 3'b001};
            mode_next = BETWEEN;
            held_next = '0;
            hv_next   = 1'b0;
            pb_next   = 1'b0;
            thc_next  = 1'b0;
            qc_next   = '0;
        end
    end

    assign push      = accept && (|bundle.valid);
    assign push_data = bundle;

    // Hold scan state; advance on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= BETWEEN;
            held_reg <= '0;
            hv_reg   <= 1'b0;
            pb_reg   <= 1'b0;
            thc_reg  <= 1'b0;
            qc_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            hv_reg   <= hv_next;
            pb_reg   <= pb_next;
            thc_reg  <= thc_next;
            qc_reg   <= qc_next;
        end
    end

endmodule

FILE: hdl/swt_queue.sv
module swt_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  swt_pkg::swt_bundle_t push_data,
    output logic                 full,
    input  logic                 pop,
    output swt_pkg::swt_bundle_t head,
    output logic                 head_valid
);

    swt_pkg::swt_bundle_t          mem_reg [swt_pkg::QDEPTH];
    logic [swt_pkg::QAW-1:0]       wr_reg, rd_reg;
    logic [swt_pkg::QCW-1:0]       cnt_reg;

    assign full       = (cnt_reg == swt_pkg::QCW'(swt_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    // Store pushed bundles
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    // Advance pointers and track fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/swt_back.sv
`include "assert_macros.svh"

module swt_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swt_pkg::swt_bundle_t head,
    input  logic                 head_valid,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           byte_out,
    output logic                 has_byte,
    output logic                 token_end,
    output logic                 line_end
);

    logic [1:0]                 sel_reg, sel_next;
    logic                       out_valid_reg;
    swt_pkg::swt_result_t       out_reg;

    logic [swt_pkg::SLOTS-1:0]  mask, cand;
    logic [1:0]                 idx;
    logic                       any, rest, load;

    // Pick the next valid slot of the head bundle at or after sel
    always_comb
    begin
        case (sel_reg)
            2'd0:    mask = 3'b111;
            2'd1:    mask = 3'b110;
            default: mask = 3'b100;
        endcase
        cand = head.valid & mask & {swt_pkg::SLOTS{head_valid}};
        any  = |cand;
        if (cand[0])
        begin
            idx  = 2'd0;
            rest = |cand[2:1];
        end
        else if (cand[1])
        begin
            idx  = 2'd1;
            rest = cand[2];
        end
        else
        begin
            idx  = 2'd2;
            rest = 1'b0;
        end
    end

    assign load     = any && (!out_valid_reg || out_ready);
    assign pop      = load && !rest;
    assign sel_next = pop ? 2'd0 : 2'(idx + 2'd1);

    // Hold the output beat until taken; refill from the queue head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                sel_reg       <= sel_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= head.res[idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = out_reg.byte_out;
    assign has_byte  = out_reg.has_byte;
    assign token_end = out_reg.token_end;
    assign line_end  = out_reg.line_end;

    `SWT_ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, head_valid, "pop from empty queue")
    `SWT_ASSERT(a_sel_range, clk, rst_n, sel_reg != 2'd3, "slot select out of range")
    `SWT_ASSERT_IMPL(a_marker_clean, clk, rst_n, out_valid_reg && out_reg.line_end,
                     !out_reg.has_byte && !out_reg.token_end, "line marker carries token")

endmodule

FILE: hdl/shell_word_tokenizer.sv
// Shell-style word splitter.
// Input channel (in_valid/in_ready): one line character per beat in byte_in,
// line_last set on the final character of the line.
// Output channel (out_valid/out_ready): one result per beat; byte_out with
// has_byte is a word character, token_end closes a word (empty if has_byte
// is low), and line_end marks the last result of each line.
// Each word character leaves only once the next character arrives, since
// a one-byte hold decides backslash drops and the last-byte mark.
// Throughput: one input beat per cycle while the queue is not full; an input
// beat causes zero to three results, and the output register drains one
// result per cycle while out_ready is high.
// A beat's first result enters the queue at the accepting edge, then moves
// to the output register, from which the receiver takes it.
// A four-entry queue of per-beat result bundles sits between the classifying
// front and the output back; in_ready drops only when that queue is full,
// so a stalled receiver back-pressures the input after four queued beats.
// Reset (rst_n low, asynchronous) returns to the between-words state and
// empties the queue and output register.
module shell_word_tokenizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       line_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] byte_out,
    output logic       has_byte,
    output logic       token_end,
    output logic       line_end
);

    logic                 q_full, push, pop, head_valid;
    swt_pkg::swt_bundle_t push_data, head;

    swt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .line_last (line_last),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    swt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    swt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .byte_out   (byte_out),
        .has_byte   (has_byte),
        .token_end  (token_end),
        .line_end   (line_end)
    );

endmodule
